// ===== rtl/qapm_pkg.sv =====
package qapm_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS      = 8;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int MIX_SHIFT      = FRAC_BITS + GAIN_FRAC_BITS;

   // Field and datapath widths
   localparam int IN_W    = 24;
   localparam int ERR_W   = IN_W + 1;
   localparam int GAIN_W  = 16;
   localparam int INTEG_W = 32;
   localparam int DERIV_W = 32;
   localparam int DUTY_W  = 8;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 56;

   localparam int NUM_AXES   = 3;
   localparam int NUM_MOTORS = 4;

   // Tick period is 1/DT_RECIP seconds
   localparam int DT_RECIP    = 50;
   localparam int RECIP_SHIFT = 32;
   // ceil(2^RECIP_SHIFT / DT_RECIP); exact floor divide for values below 2^25
   localparam longint unsigned RECIP_MUL =
      ((64'd1 << RECIP_SHIFT) + 64'(DT_RECIP) - 64'd1) / 64'(DT_RECIP);
   localparam int DUTY_MAX = 255;

   // Gain register indexes
   typedef enum logic [1:0] {
      CSR_PROP     = 2'd0,
      CSR_INTEG    = 2'd1,
      CSR_DERIV    = 2'd2,
      CSR_THROTTLE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [IN_W-1:0] meas_roll;
      logic signed [IN_W-1:0] meas_pitch;
      logic signed [IN_W-1:0] meas_yaw;
      logic signed [IN_W-1:0] meas_alt;
      logic signed [IN_W-1:0] want_roll;
      logic signed [IN_W-1:0] want_pitch;
      logic signed [IN_W-1:0] want_yaw;
      logic signed [IN_W-1:0] want_alt;
   } req_data_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_front_a;
      logic [DUTY_W-1:0] duty_front_b;
      logic [DUTY_W-1:0] duty_rear_b;
      logic [DUTY_W-1:0] duty_rear_a;
   } rsp_data_type;

endpackage

// ===== rtl/quad_attitude_pid_mixer.sv =====
// Attitude PID and quad-X motor mixer.
//
// Input channel req_*: one word per control tick carrying measured and target
// roll, pitch, yaw and altitude (signed Q15.8). Output channel rsp_*: one word
// with four motor duties 0..255 per input word. Both use valid/ready.
// csr_*: write-only gain registers (prop, integ, deriv, throttle; Q4.12),
// written on csr_we with no wait.
//
// All multiplies go through one 33x32 signed multiplier driven by a step
// counter: two multiplies build the base throttle, then four per axis
// (divide-by-50 reciprocal, P, I, D). The product is registered, so the
// sequence is 14 issues, a drain step in S_RUN for the last product, then
// S_DONE loads the output word. rsp_valid rises when the word is loaded and
// req_ready returns with it, so a new item is not taken until the last one
// is through.
// req_ready is low while an item is in work. If the receiver stalls, the
// finished item waits in the sequencer until the output register frees.
// Reset (synchronous, active high) restores default gains and clears
// integrators, previous errors and the output valid.
module quad_attitude_pid_mixer import qapm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_data_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_data_type       rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [GAIN_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      SUB_DIV = 2'd0,
      SUB_P   = 2'd1,
      SUB_I   = 2'd2,
      SUB_D   = 2'd3
   } sub_type;

   localparam logic [3:0] STEP_PT    = 4'd0;
   localparam logic [3:0] STEP_BASE  = 4'd1;
   localparam logic [3:0] STEP_AXIS  = 4'd2;
   localparam logic [3:0] STEP_LAST  = 4'd13;

   // Mix sign per axis (roll, pitch, yaw) and motor (fa, fb, rb, ra): 1 = subtract
   localparam logic [NUM_AXES-1:0][NUM_MOTORS-1:0] MIX_NEG = '{
      4'b1010,   // yaw: fa+, fb-, rb+, ra-
      4'b0011,   // pitch: fa-, fb-, rb+, ra+
      4'b0110    // roll: fa+, fb-, rb-, ra+
   };

   localparam logic signed [INTEG_W:0] INTEG_MAX = (INTEG_W+1)'((64'd1 << (INTEG_W-1)) - 1);
   localparam logic signed [INTEG_W:0] INTEG_MIN = -(INTEG_MAX + 1);

   // Registers
   state_type                    state_ff, state_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic                         cons_valid_ff, cons_valid_in;
   logic [3:0]                   cons_step_ff, cons_step_in;
   logic [GAIN_W-1:0]            prop_ff, prop_in;
   logic [GAIN_W-1:0]            integ_gain_ff, integ_gain_in;
   logic [GAIN_W-1:0]            deriv_gain_ff, deriv_gain_in;
   logic [GAIN_W-1:0]            thr_ff, thr_in;
   logic signed [ERR_W-1:0]      err_ff [NUM_AXES], err_in [NUM_AXES];
   logic signed [ERR_W-1:0]      ealt_ff, ealt_in;
   logic signed [ERR_W-1:0]      prev_ff [NUM_AXES], prev_in [NUM_AXES];
   logic signed [INTEG_W-1:0]    integ_ff [NUM_AXES], integ_in [NUM_AXES];
   logic signed [ACC_W-1:0]      mix_ff [NUM_MOTORS], mix_in [NUM_MOTORS];
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_data_type                 rsp_data_ff, rsp_data_in;

   // Multiplier interface
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]     prod;

   // Step decode
   logic [3:0]                   iss_rel, cons_rel;
   logic [1:0]                   iss_ax, cons_ax;
   sub_type                      iss_sub, cons_sub;
   logic signed [ERR_W-1:0]      iss_err, cons_err;
   logic [ERR_W-1:0]             iss_abs;
   logic signed [ERR_W:0]        diff;
   logic signed [DERIV_W-1:0]    diff_x, deriv;
   logic [ERR_W-1:0]             quot;
   logic signed [INTEG_W-1:0]    cons_integ;
   logic signed [INTEG_W+1:0]    integ_sum;
   logic signed [ACC_W-1:0]      prod_acc, base_acc;
   logic                         req_fire, out_free;

   qapm_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   function automatic logic [DUTY_W-1:0] to_duty(input logic signed [ACC_W-1:0] m);
      logic signed [ACC_W-1:0] t;
      t = m >>> MIX_SHIFT;
      if (m < 0) begin
         return '0;
      end else if (t > ACC_W'(DUTY_MAX)) begin
         return DUTY_W'(DUTY_MAX);
      end
      return t[DUTY_W-1:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Issue-side operand select
   always_comb begin
      iss_rel = cnt_ff - STEP_AXIS;
      iss_ax  = iss_rel[3:2];
      iss_sub = sub_type'(iss_rel[1:0]);
      iss_err = (iss_ax < 2'(NUM_AXES)) ? err_ff[iss_ax] : '0;
      iss_abs = iss_err[ERR_W-1] ? ERR_W'(-iss_err) : ERR_W'(iss_err);
      diff    = (ERR_W+1)'(iss_err) - (ERR_W+1)'(prev_ff[(iss_ax < 2'(NUM_AXES)) ? iss_ax : 2'd0]);
      diff_x  = DERIV_W'(diff);
      // times 50 as 32 + 16 + 2
      deriv   = (diff_x <<< 5) + (diff_x <<< 4) + (diff_x <<< 1);

      mul_a = '0;
      mul_b = '0;
      if (cnt_ff == STEP_PT) begin
         mul_a = MUL_A_W'({1'b0, prop_ff});
         mul_b = MUL_B_W'({1'b0, thr_ff});
      end else if (cnt_ff == STEP_BASE) begin
         mul_a = {1'b0, prod[MUL_B_W-1:0]};
         mul_b = MUL_B_W'(ealt_ff);
      end else begin
         unique case (iss_sub)
            SUB_DIV: begin
               mul_a = MUL_A_W'(RECIP_MUL);
               mul_b = MUL_B_W'({1'b0, iss_abs}) + MUL_B_W'(DT_RECIP / 2);
            end
            SUB_P: begin
               mul_a = MUL_A_W'({1'b0, prop_ff});
               mul_b = MUL_B_W'(iss_err);
            end
            SUB_I: begin
               mul_a = MUL_A_W'({1'b0, integ_gain_ff});
               mul_b = (iss_ax < 2'(NUM_AXES)) ? integ_ff[iss_ax] : '0;
            end
            SUB_D: begin
               mul_a = MUL_A_W'({1'b0, deriv_gain_ff});
               mul_b = deriv;
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   // Consume-side decode of the product registered last cycle
   always_comb begin
      cons_rel   = cons_step_ff - STEP_AXIS;
      cons_ax    = cons_rel[3:2];
      cons_sub   = sub_type'(cons_rel[1:0]);
      cons_err   = (cons_ax < 2'(NUM_AXES)) ? err_ff[cons_ax] : '0;
      cons_integ = (cons_ax < 2'(NUM_AXES)) ? integ_ff[cons_ax] : '0;
      quot       = prod[RECIP_SHIFT +: ERR_W];
      integ_sum  = (INTEG_W+2)'(cons_integ)
                 + (cons_err[ERR_W-1] ? -(INTEG_W+2)'({1'b0, quot})
                                      : (INTEG_W+2)'({1'b0, quot}));
      prod_acc   = prod[ACC_W-1:0];
      base_acc   = ACC_W'(prod >>> GAIN_FRAC_BITS);
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cons_valid_in = 1'b0;
      cons_step_in  = cnt_ff;
      prop_in       = prop_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      thr_in        = thr_ff;
      ealt_in       = ealt_ff;
      err_in        = err_ff;
      prev_in       = prev_ff;
      integ_in      = integ_ff;
      mix_in        = mix_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      // Gain register writes
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP:     prop_in       = csr_wdata;
            CSR_INTEG:    integ_gain_in = csr_wdata;
            CSR_DERIV:    deriv_gain_in = csr_wdata;
            CSR_THROTTLE: thr_in        = csr_wdata;
            default:      prop_in       = prop_ff;
         endcase
      end

      // Fold in the product from last cycle's issue
      if (cons_valid_ff) begin
         if (cons_step_ff == STEP_BASE) begin
            for (int j = 0; j < NUM_MOTORS; j++) begin
               mix_in[j] = base_acc;
            end
         end else if (cons_step_ff != STEP_PT && cons_ax < 2'(NUM_AXES)) begin
            if (cons_sub == SUB_DIV) begin
               if (integ_sum > (INTEG_W+2)'(INTEG_MAX)) begin
                  integ_in[cons_ax] = INTEG_MAX[INTEG_W-1:0];
               end else if (integ_sum < (INTEG_W+2)'(INTEG_MIN)) begin
                  integ_in[cons_ax] = INTEG_MIN[INTEG_W-1:0];
               end else begin
                  integ_in[cons_ax] = integ_sum[INTEG_W-1:0];
               end
            end else begin
               for (int j = 0; j < NUM_MOTORS; j++) begin
                  mix_in[j] = MIX_NEG[cons_ax][j] ? mix_ff[j] - prod_acc
                                                  : mix_ff[j] + prod_acc;
               end
            end
         end
      end

      // Sequencer
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               err_in[0] = ERR_W'(req_data.want_roll) - ERR_W'(req_data.meas_roll);
               err_in[1] = ERR_W'(req_data.want_pitch) - ERR_W'(req_data.meas_pitch);
               err_in[2] = ERR_W'(req_data.want_yaw) - ERR_W'(req_data.meas_yaw);
               ealt_in   = ERR_W'(req_data.want_alt) - ERR_W'(req_data.meas_alt);
               cnt_in    = STEP_PT;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            if (cnt_ff <= STEP_LAST) begin
               cons_valid_in = 1'b1;
               cnt_in        = cnt_ff + 4'd1;
               if (cnt_ff != STEP_PT && cnt_ff != STEP_BASE && iss_sub == SUB_D
                   && iss_ax < 2'(NUM_AXES)) begin
                  prev_in[iss_ax] = iss_err;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.duty_front_a = to_duty(mix_ff[0]);
               rsp_data_in.duty_front_b = to_duty(mix_ff[1]);
               rsp_data_in.duty_rear_b  = to_duty(mix_ff[2]);
               rsp_data_in.duty_rear_a  = to_duty(mix_ff[3]);
               cnt_in                   = STEP_PT;
               state_in                 = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= STEP_PT;
         cons_valid_ff <= 1'b0;
         cons_step_ff  <= STEP_PT;
         prop_ff       <= GAIN_W'(8192);
         integ_gain_ff <= GAIN_W'(205);
         deriv_gain_ff <= GAIN_W'(4096);
         thr_ff        <= GAIN_W'(5803);
         for (int i = 0; i < NUM_AXES; i++) begin
            prev_ff[i]  <= '0;
            integ_ff[i] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cons_valid_ff <= cons_valid_in;
         cons_step_ff  <= cons_step_in;
         prop_ff       <= prop_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         thr_ff        <= thr_in;
         prev_ff       <= prev_in;
         integ_ff      <= integ_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      err_ff      <= err_in;
      ealt_ff     <= ealt_in;
      mix_ff      <= mix_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("req_ready high right after accept");

   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cnt_ff == STEP_PT) && !cons_valid_ff)
      else $error("sequencer active while idle");

   a_integ_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(integ_ff[0]) && $stable(integ_ff[1])
                               && $stable(integ_ff[2]))
      else $error("integrator moved outside the sequence");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("output word overwritten while stalled");

endmodule

// ===== rtl/qapm_mul.sv =====
// Shared signed multiplier, product registered
module qapm_mul import qapm_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
